@@ rtl/thbf_pkg.sv @@
// ----------------------------------------------------------------------------
// thbf_pkg: shared types and constants for the two-hash Bloom filter
// Request and response payloads, hash seeds and fixed widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package thbf_pkg;

   // Fixed widths
   localparam int HASH_W     = 32;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = 5;                  // bit index inside a word
   localparam int DIVIDEND_W = HASH_W - BIT_W;     // word part of a hash
   localparam int WORDS_W    = 11;                 // size register width
   localparam int STEP_W     = 5;                  // divider step counter
   localparam int BYTE_W     = 8;

   // Hash seeds
   localparam logic [HASH_W-1:0] DJB2_SEED = 32'd5381;
   localparam logic [HASH_W-1:0] SDBM_SEED = 32'd0;

   // Request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] key_byte;
      logic              key_last;
   } req_payload_type;

   typedef struct packed {
      logic was_query;
      logic maybe_present;
   } rsp_payload_type;

   // Status from the shared modulo unit
   typedef struct packed {
      logic               done;
      logic [WORDS_W-1:0] rem;
   } mod_status_type;

endpackage

@@ rtl/thbf_ram.sv @@
// ----------------------------------------------------------------------------
// thbf_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thbf_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/thbf_mod_unit.sv @@
// ----------------------------------------------------------------------------
// thbf_mod_unit: iterative modulo unit
// Restoring radix-2 remainder of the word part of a hash by the word count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thbf_mod_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [thbf_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [thbf_pkg::WORDS_W-1:0]        divisor,
   output thbf_pkg::mod_status_type            status
);

   import thbf_pkg::*;

   logic [DIVIDEND_W-1:0] dividend_ff, dividend_in;
   logic [WORDS_W-1:0]    divisor_ff, divisor_in;
   logic [WORDS_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [WORDS_W:0]      trial;

   // One shift-and-subtract step
   always_comb begin
      trial       = {rem_ff, dividend_ff[DIVIDEND_W-1]};
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      if (start) begin
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
         step_in     = STEP_W'(DIVIDEND_W - 1);
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = WORDS_W'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = WORDS_W'(trial);
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
   end

   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule

@@ rtl/two_hash_bloom_filter_unit.sv @@
// ----------------------------------------------------------------------------
// two_hash_bloom_filter_unit: two-hash Bloom filter over byte-serial keys
// Keeps djb2-xor and sdbm running hashes; on the last key byte it maps both
// hashes into a bitmap of csr-selected size and sets or tests two bits.
// ----------------------------------------------------------------------------
// Usage:
//   Keys arrive on the req_ channel one byte per request, key_last marking the
//   final byte; the kind given with that byte decides insert or query.
//   Each key produces one response on the rsp_ channel: was_query, and for a
//   query maybe_present (set when both hashed bits are set).
//   A non-final byte is taken without leaving the idle state, so req_stall stays
//   low and such bytes can follow back to back.
//   A final byte is followed by two passes through the single bit-serial modulo
//   unit, then two bitmap accesses (a read and, for an insert, a write-back)
//   on the one bitmap RAM port pair; the unit returns to idle at the same edge
//   that loads the response, and can take the next request while it is held.
//   The response sits in an output register; while rsp_stall holds it, the
//   unit keeps taking non-final bytes and only waits once the next response
//   is ready to be loaded.
//   After reset the bitmap is swept to zero, one word per cycle, through all
//   MAX_WORDS words, and req_stall stays high meanwhile. csr_wr_en writes
//   the word count (0 acts as 1, above MAX_WORDS acts as MAX_WORDS); write it
//   only while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_hash_bloom_filter_unit #(
   parameter int MAX_WORDS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  thbf_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output thbf_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [thbf_pkg::WORDS_W-1:0]     csr_wr_data
);

   import thbf_pkg::*;

   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_MOD1  = 9'b000000100,
      S_MOD2  = 9'b000001000,
      S_RD1   = 9'b000010000,
      S_WR1   = 9'b000100000,
      S_RD2   = 9'b001000000,
      S_WR2   = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic [WORDS_W-1:0]    words_cfg_ff, words_cfg_in;
   logic [WORDS_W-1:0]    words_ff, words_in;
   logic [HASH_W-1:0]     djb2_ff, djb2_in;
   logic [HASH_W-1:0]     sdbm_ff, sdbm_in;
   logic [ADDR_W-1:0]     word1_ff, word1_in;
   logic [ADDR_W-1:0]     word2_ff, word2_in;
   logic [ADDR_W-1:0]     clear_cnt_ff, clear_cnt_in;
   logic                  kind_ff, kind_in;
   logic                  present_ff, present_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic [HASH_W-1:0]     byte_ext;
   logic [HASH_W-1:0]     djb2_next;
   logic [HASH_W-1:0]     sdbm_next;
   logic [WORDS_W-1:0]    words_clamped;

   logic                  mod_start;
   logic [DIVIDEND_W-1:0] mod_dividend;
   logic [WORDS_W-1:0]    mod_divisor;
   mod_status_type        mod_status;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [WORD_BITS-1:0]  ram_wr_data;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [WORD_BITS-1:0]  ram_rd_data;
   logic [BIT_W-1:0]      bit_sel;
   logic [WORD_BITS-1:0]  bit_mask;
   logic                  bit_hit;

   // Handshake
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Running hash update for the incoming byte
   assign byte_ext  = HASH_W'(req_payload.key_byte);
   assign djb2_next = ((djb2_ff << 5) + djb2_ff) ^ byte_ext;
   assign sdbm_next = byte_ext + (sdbm_ff << 6) + (sdbm_ff << 16) - sdbm_ff;

   // Word count in force, clamped to the bitmap size
   always_comb begin
      words_clamped = words_cfg_ff;
      if (words_cfg_ff == '0) begin
         words_clamped = WORDS_W'(1);
      end else if (32'(words_cfg_ff) > MAX_WORDS) begin
         words_clamped = WORDS_W'(MAX_WORDS);
      end
   end

   // Modulo unit feed: first hash at key end, second after the first finishes
   always_comb begin
      mod_start    = 1'b0;
      mod_dividend = sdbm_ff[HASH_W-1:BIT_W];
      mod_divisor  = words_ff;
      if (state_ff == S_IDLE && req_accept && req_payload.key_last) begin
         mod_start    = 1'b1;
         mod_dividend = djb2_next[HASH_W-1:BIT_W];
         mod_divisor  = words_clamped;
      end else if (state_ff == S_MOD1 && mod_status.done) begin
         mod_start = 1'b1;
      end
   end

   thbf_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .divisor  (mod_divisor),
      .status   (mod_status)
   );

   // Bitmap access
   assign bit_sel  = (state_ff == S_WR2) ? sdbm_ff[BIT_W-1:0] : djb2_ff[BIT_W-1:0];
   assign bit_mask = WORD_BITS'(1) << bit_sel;
   assign bit_hit  = (ram_rd_data & bit_mask) != '0;

   always_comb begin
      ram_rd_addr = (state_ff == S_RD2) ? word2_ff : word1_ff;
      ram_wr_addr = (state_ff == S_WR2) ? word2_ff : word1_ff;
      ram_wr_data = ram_rd_data | bit_mask;
      ram_wr_en   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_cnt_ff;
            ram_wr_data = '0;
         end
         S_WR1, S_WR2: begin
            ram_wr_en = (kind_ff == KIND_INSERT);
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   thbf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      words_cfg_in   = csr_wr_en ? csr_wr_data : words_cfg_ff;
      words_in       = words_ff;
      djb2_in        = djb2_ff;
      sdbm_in        = sdbm_ff;
      word1_in       = word1_ff;
      word2_in       = word2_ff;
      clear_cnt_in   = clear_cnt_ff;
      kind_in        = kind_ff;
      present_in     = present_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         S_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == ADDR_W'(MAX_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               djb2_in = djb2_next;
               sdbm_in = sdbm_next;
               if (req_payload.key_last) begin
                  kind_in    = req_payload.kind;
                  words_in   = words_clamped;
                  present_in = 1'b1;
                  state_in   = S_MOD1;
               end
            end
         end
         S_MOD1: begin
            if (mod_status.done) begin
               word1_in = ADDR_W'(mod_status.rem);
               state_in = S_MOD2;
            end
         end
         S_MOD2: begin
            if (mod_status.done) begin
               word2_in = ADDR_W'(mod_status.rem);
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            state_in = S_WR1;
         end
         S_WR1: begin
            present_in = present_ff && bit_hit;
            state_in   = S_RD2;
         end
         S_RD2: begin
            state_in = S_WR2;
         end
         S_WR2: begin
            present_in = present_ff && bit_hit;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.was_query     = kind_ff;
               rsp_payload_in.maybe_present = (kind_ff == KIND_QUERY) && present_ff;
               djb2_in                      = DJB2_SEED;
               sdbm_in                      = SDBM_SEED;
               state_in                     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_cnt_ff <= '0;
         words_cfg_ff <= WORDS_W'(1024);
         djb2_ff      <= DJB2_SEED;
         sdbm_ff      <= SDBM_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         words_cfg_ff <= words_cfg_in;
         djb2_ff      <= djb2_in;
         sdbm_ff      <= sdbm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      words_ff       <= words_in;
      word1_ff       <= word1_in;
      word2_ff       <= word2_in;
      kind_ff        <= kind_in;
      present_ff     <= present_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
